// ===== rtl/mlrq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared types and constants of the multilevel ready-queue scheduler.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int PRIORITY_LEVELS = 64;
  localparam int THREAD_SLOTS    = 64;

  localparam int LVL_W = $clog2(PRIORITY_LEVELS);
  localparam int ID_W  = $clog2(THREAD_SLOTS);
  localparam int CNT_W = 7;

  // level scan walks groups of GROUP_W levels, highest group first
  localparam int GROUP_W    = 8;
  localparam int NUM_GROUPS = PRIORITY_LEVELS / GROUP_W;
  localparam int GRP_W      = $clog2(NUM_GROUPS);
  localparam int POS_W      = $clog2(GROUP_W);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_SELECT  = 2'd1;
  localparam logic [1:0] MODE_YIELD   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_RD,
    ST_PUSH_LNK,
    ST_SEL_GO,
    ST_SEL_WAIT,
    ST_POP_RD,
    ST_POP_CHK,
    ST_POP_LNK,
    ST_YLD_GO,
    ST_YLD_WAIT,
    ST_FIN_GO,
    ST_FIN_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ID_W-1:0]  thread_id;
    logic [LVL_W-1:0] priority_req;
    logic             is_idle;
    logic [LVL_W-1:0] running_priority;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  next_id;
    logic             next_valid;
    logic             keep_running;
    logic             preempt_request;
    logic [LVL_W-1:0] top_level;
    logic             any_ready;
    logic [CNT_W-1:0] ready_total;
    logic             duplicate_error;
  } res_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [LVL_W-1:0] level;
  } scan_stat_t;

  typedef struct packed {
    logic req_ready;
    logic res_valid;
  } ctrl_stat_t;

endpackage

// ===== rtl/mlrq_scan.sv =====
// ----------------------------------------------------------------------------
// mlrq_scan
// Iterative highest-set-bit search over the level occupancy vector, one
// group of levels per cycle, top group first. done pulses for one cycle.
// ----------------------------------------------------------------------------
module mlrq_scan
  import mlrq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [PRIORITY_LEVELS-1:0] vec,
  output scan_stat_t                 stat
);

  logic             busy_r, busy_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             done_r, done_nxt;
  logic             found_r, found_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  logic [GROUP_W-1:0] grp_bits;
  logic [POS_W-1:0]   pos;

  always_comb begin
    grp_bits = vec[grp_r*GROUP_W +: GROUP_W];
    pos      = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      if (grp_bits[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    grp_nxt   = grp_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    level_nxt = level_r;
    if (start) begin
      busy_nxt = 1'b1;
      grp_nxt  = GRP_W'(NUM_GROUPS - 1);
    end else if (busy_r) begin
      if (|grp_bits) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b1;
        level_nxt = {grp_r, pos};
      end else if (grp_r == '0) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b0;
        level_nxt = '0;
      end else begin
        grp_nxt = grp_r - GRP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      level_r <= '0;
      grp_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      level_r <= level_nxt;
      grp_r   <= grp_nxt;
    end
  end

  assign stat.done  = done_r;
  assign stat.found = found_r;
  assign stat.level = level_r;

endmodule

// ===== rtl/mlrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Request sequencer: queue memories (head, tail, link), occupancy and
// queued bits, ready counter, and the shared level scan.
// ----------------------------------------------------------------------------
module mlrq_ctrl
  import mlrq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_accept,
  input  req_t       req,
  input  logic       res_take,
  output ctrl_stat_t stat,
  output res_t       res
);

  state_t state_r, state_nxt;

  // captured request
  logic [1:0]       mode_r, mode_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [LVL_W-1:0] prio_r, prio_nxt;
  logic             idle_r, idle_nxt;
  logic [LVL_W-1:0] run_r, run_nxt;

  // scheduler state
  logic [PRIORITY_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [THREAD_SLOTS-1:0]    queued_r, queued_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  // result under construction
  logic [ID_W-1:0]  nid_r, nid_nxt;
  logic             nval_r, nval_nxt;
  logic             keep_r, keep_nxt;
  logic             pre_r, pre_nxt;
  logic             dup_r, dup_nxt;
  logic [LVL_W-1:0] top_r, top_nxt;
  logic             any_r, any_nxt;

  // queue memories
  logic [ID_W-1:0] head_mem [PRIORITY_LEVELS];
  logic [ID_W-1:0] tail_mem [PRIORITY_LEVELS];
  logic [ID_W-1:0] link_mem [THREAD_SLOTS];

  logic             head_we, tail_we, link_we;
  logic [LVL_W-1:0] head_waddr, tail_waddr, head_raddr, tail_raddr;
  logic [ID_W-1:0]  link_waddr, link_raddr;
  logic [ID_W-1:0]  head_wdata, tail_wdata, link_wdata;
  logic [ID_W-1:0]  head_q, tail_q, link_q;

  logic       scan_start;
  scan_stat_t scan;

  logic dup_hit;
  logic push_commit;
  logic yield_keep;

  mlrq_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .vec   (nonempty_r),
    .stat  (scan)
  );

  assign dup_hit = ((mode_r == MODE_ENQUEUE) || ((mode_r == MODE_YIELD) && !idle_r))
                   && queued_r[id_r];
  assign push_commit = ((state_r == ST_PUSH_RD) && !nonempty_r[prio_r]) ||
                       (state_r == ST_PUSH_LNK);
  assign yield_keep  = scan.found && (prio_r > scan.level);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (dup_hit) begin
          state_nxt = ST_FIN_GO;
        end else if (mode_r == MODE_ENQUEUE) begin
          state_nxt = ST_PUSH_RD;
        end else if (mode_r == MODE_SELECT) begin
          state_nxt = ST_SEL_GO;
        end else if (mode_r == MODE_YIELD) begin
          state_nxt = idle_r ? ST_SEL_GO : ST_YLD_GO;
        end else begin
          state_nxt = ST_FIN_GO;
        end
      end
      ST_PUSH_RD: begin
        if (nonempty_r[prio_r]) begin
          state_nxt = ST_PUSH_LNK;
        end else begin
          state_nxt = (mode_r == MODE_YIELD) ? ST_SEL_GO : ST_FIN_GO;
        end
      end
      ST_PUSH_LNK: state_nxt = (mode_r == MODE_YIELD) ? ST_SEL_GO : ST_FIN_GO;
      ST_SEL_GO:   state_nxt = ST_SEL_WAIT;
      ST_SEL_WAIT: begin
        if (scan.done) state_nxt = scan.found ? ST_POP_RD : ST_FIN_GO;
      end
      ST_POP_RD:  state_nxt = ST_POP_CHK;
      ST_POP_CHK: state_nxt = (head_q == tail_q) ? ST_FIN_GO : ST_POP_LNK;
      ST_POP_LNK: state_nxt = ST_FIN_GO;
      ST_YLD_GO:  state_nxt = ST_YLD_WAIT;
      ST_YLD_WAIT: begin
        if (scan.done) state_nxt = yield_keep ? ST_FIN_GO : ST_PUSH_RD;
      end
      ST_FIN_GO:   state_nxt = ST_FIN_WAIT;
      ST_FIN_WAIT: begin
        if (scan.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mode_nxt     = mode_r;
    id_nxt       = id_r;
    prio_nxt     = prio_r;
    idle_nxt     = idle_r;
    run_nxt      = run_r;
    nonempty_nxt = nonempty_r;
    queued_nxt   = queued_r;
    cnt_nxt      = cnt_r;
    nid_nxt      = nid_r;
    nval_nxt     = nval_r;
    keep_nxt     = keep_r;
    pre_nxt      = pre_r;
    dup_nxt      = dup_r;
    top_nxt      = top_r;
    any_nxt      = any_r;
    scan_start   = 1'b0;
    head_we      = 1'b0;
    tail_we      = 1'b0;
    link_we      = 1'b0;
    head_waddr   = scan.level;
    head_wdata   = link_q;
    tail_waddr   = prio_r;
    tail_wdata   = id_r;
    link_waddr   = tail_q;
    link_wdata   = id_r;
    head_raddr   = scan.level;
    tail_raddr   = scan.level;
    link_raddr   = head_q;

    // enqueue bookkeeping shared by both push paths
    if (push_commit) begin
      tail_we          = 1'b1;
      queued_nxt[id_r] = 1'b1;
      if (!idle_r && (cnt_r != CNT_MAX)) cnt_nxt = cnt_r + CNT_W'(1);
      pre_nxt = (mode_r == MODE_ENQUEUE) && (prio_r > run_r);
    end

    case (state_r)
      ST_IDLE: begin
        if (req_accept) begin
          mode_nxt = req.mode;
          id_nxt   = req.thread_id;
          prio_nxt = req.priority_req;
          idle_nxt = req.is_idle;
          run_nxt  = req.running_priority;
          nid_nxt  = '0;
          nval_nxt = 1'b0;
          keep_nxt = 1'b0;
          pre_nxt  = 1'b0;
          dup_nxt  = 1'b0;
        end
      end
      ST_DECODE: begin
        dup_nxt = dup_hit;
      end
      ST_PUSH_RD: begin
        tail_raddr = prio_r;
        if (!nonempty_r[prio_r]) begin
          head_we              = 1'b1;
          head_waddr           = prio_r;
          head_wdata           = id_r;
          nonempty_nxt[prio_r] = 1'b1;
        end
      end
      ST_PUSH_LNK: begin
        link_we = 1'b1;
      end
      ST_SEL_GO, ST_YLD_GO, ST_FIN_GO: begin
        scan_start = 1'b1;
      end
      ST_YLD_WAIT: begin
        if (scan.done && yield_keep) begin
          nid_nxt  = id_r;
          nval_nxt = 1'b1;
          keep_nxt = 1'b1;
        end
      end
      ST_POP_CHK: begin
        queued_nxt[head_q] = 1'b0;
        if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
        nid_nxt  = head_q;
        nval_nxt = 1'b1;
        if (head_q == tail_q) nonempty_nxt[scan.level] = 1'b0;
      end
      ST_POP_LNK: begin
        head_we = 1'b1;
      end
      ST_FIN_WAIT: begin
        if (scan.done) begin
          top_nxt = scan.found ? scan.level : '0;
          any_nxt = scan.found;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
    if (link_we) link_mem[link_waddr] <= link_wdata;
    head_q <= head_mem[head_raddr];
    tail_q <= tail_mem[tail_raddr];
    link_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      nonempty_r <= '0;
      queued_r   <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      nonempty_r <= nonempty_nxt;
      queued_r   <= queued_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
    idle_r <= idle_nxt;
    run_r  <= run_nxt;
    nid_r  <= nid_nxt;
    nval_r <= nval_nxt;
    keep_r <= keep_nxt;
    pre_r  <= pre_nxt;
    dup_r  <= dup_nxt;
    top_r  <= top_nxt;
    any_r  <= any_nxt;
  end

  assign stat.req_ready = (state_r == ST_IDLE);
  assign stat.res_valid = (state_r == ST_DONE);

  assign res.next_id         = nid_r;
  assign res.next_valid      = nval_r;
  assign res.keep_running    = keep_r;
  assign res.preempt_request = pre_r;
  assign res.top_level       = top_r;
  assign res.any_ready       = any_r;
  assign res.ready_total     = cnt_r;
  assign res.duplicate_error = dup_r;

  // counted threads are a subset of queued threads
  a_cnt_le_queued: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) >= int'(cnt_r))
    else $error("ready count exceeds queued threads");

  // a non-empty level always holds some queued thread
  a_nonempty_has_thread: assert property (@(posedge clk) disable iff (!rst_n)
    (|nonempty_r) |-> (|queued_r))
    else $error("non-empty level without queued thread");

  // scan hit points at an occupied level
  a_scan_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (scan.done && scan.found) |-> nonempty_r[scan.level])
    else $error("scan reported an empty level");

  // reported top level is occupied
  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && any_r) |-> nonempty_r[top_r])
    else $error("reported top level is empty");

endmodule

// ===== rtl/multilevel_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler
// One FIFO ready queue per priority level with enqueue, select-next and
// yield requests; one result per request through an output register.
// ----------------------------------------------------------------------------
// Scans: each level scan checks one group of 8 levels per cycle, and a full yield
//   runs three.
// Throughput: one request at a time; in_stall stays high until the result enters
//   the output register.
// Reset: synchronous, active low; clears occupancy, queued bits, ready counter
//   and sequencer. Queue memories are not cleared.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler
  import mlrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [ID_W-1:0]  in_thread_id,
  input  logic [LVL_W-1:0] in_priority_req,
  input  logic             in_is_idle,
  input  logic [LVL_W-1:0] in_running_priority,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  out_next_id,
  output logic             out_next_valid,
  output logic             out_keep_running,
  output logic             out_preempt_request,
  output logic [LVL_W-1:0] out_top_level,
  output logic             out_any_ready,
  output logic [CNT_W-1:0] out_ready_total,
  output logic             out_duplicate_error
);

  req_t       req;
  res_t       res;
  ctrl_stat_t cstat;
  logic       req_accept;
  logic       res_take;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  assign req.mode             = in_mode;
  assign req.thread_id        = in_thread_id;
  assign req.priority_req     = in_priority_req;
  assign req.is_idle          = in_is_idle;
  assign req.running_priority = in_running_priority;

  // ready only while the sequencer is idle; a result waiting in the output
  // register does not block the next request
  assign in_stall   = !cstat.req_ready;
  assign req_accept = in_valid && cstat.req_ready;

  // the sequencer hands its result over once the output register is free
  assign res_take = cstat.res_valid && (!out_valid_r || !out_stall);

  mlrq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (req_accept),
    .req        (req),
    .res_take   (res_take),
    .stat       (cstat),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_next_id         = out_res_r.next_id;
  assign out_next_valid      = out_res_r.next_valid;
  assign out_keep_running    = out_res_r.keep_running;
  assign out_preempt_request = out_res_r.preempt_request;
  assign out_top_level       = out_res_r.top_level;
  assign out_any_ready       = out_res_r.any_ready;
  assign out_ready_total     = out_res_r.ready_total;
  assign out_duplicate_error = out_res_r.duplicate_error;

endmodule
